[rtl/seven_segment_digit_scan_defines.svh]
// Assertion shorthands used by the checker of this block.
`ifndef SEVEN_SEGMENT_DIGIT_SCAN_DEFINES_SVH
`define SEVEN_SEGMENT_DIGIT_SCAN_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("digit scan check failed");

// Next-cycle implication.
`define DSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("digit scan check failed");

`endif

[rtl/dss_pkg.sv]
`default_nettype none

package dss_pkg;

  // Fixed field widths
  localparam int ValueW = 16;
  localparam int SegW   = 7;
  localparam int EnW    = 4;
  localparam int DigitW = 4;

  // At most four digits fit the enable field
  localparam int MaxScan = 4;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [16:0] Recip10 = 17'd52429;
  localparam int RecipShift = 19;
  localparam int ProdW = ValueW + 17;

  // Digit store: ones digit at index 0
  typedef logic [MaxScan-1:0][DigitW-1:0] digits_t;

  typedef struct packed {
    logic [ValueW-1:0] rest;
    digits_t           digits;
  } work_t;

  // Common-cathode pattern, bit0 = a .. bit6 = g
  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/dss_value_if.sv]
`default_nettype none

interface dss_value_if;
  logic                      valid;
  logic                      ready;
  logic [dss_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

[rtl/dss_digit_if.sv]
`default_nettype none

interface dss_digit_if;
  logic                     valid;
  logic                     ready;
  logic [dss_pkg::SegW-1:0] segments;
  logic [dss_pkg::EnW-1:0]  digit_enable_n;
  logic                     last;

  modport source (output valid, output segments, output digit_enable_n, output last,
                  input ready);
  modport sink   (input valid, input segments, input digit_enable_n, input last,
                  output ready);
endinterface

`default_nettype wire

[rtl/seven_segment_digit_scan.sv]
// A value passes through one register stage per digit (the first loads at the edge that
// accepts it), then the scan register, which shows its most significant digit first.
// Scan is DIGITS held to 1..4.
// Throughput: one digit result per cycle while the result side is ready, set by the
// single result port; the divider stages take a value every cycle unless a later stage stalls.
// Reset (synchronous, active high) empties every stage and the scan register.
`default_nettype none

module seven_segment_digit_scan #(
  parameter int DIGITS = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dss_value_if.sink   num,
  dss_digit_if.source digit
);

  localparam int Scan = (DIGITS < 1) ? 1 :
                        (DIGITS > dss_pkg::MaxScan) ? dss_pkg::MaxScan : DIGITS;

  logic [Scan:0]  vld;
  logic [Scan:0]  rdy;
  dss_pkg::work_t wk [Scan+1];

  // Pipeline entry
  assign vld[0]    = num.valid;
  assign num.ready = rdy[0];
  assign wk[0]     = '{rest: num.value, digits: '0};

  // One divide-by-ten stage per digit
  for (genvar k = 0; k < Scan; k++) begin : g_stage
    dss_div_stage #(
      .POS (k)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .feed_valid (vld[k]),
      .feed_ready (rdy[k]),
      .feed       (wk[k]),
      .done_valid (vld[k+1]),
      .done_ready (rdy[k+1]),
      .done       (wk[k+1])
    );
  end

  // Digit scan out
  dss_scan #(
    .COUNT (Scan)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (vld[Scan]),
    .feed_ready (rdy[Scan]),
    .feed       (wk[Scan].digits),
    .digit      (digit)
  );

endmodule

`default_nettype wire

[rtl/dss_div_stage.sv]
`default_nettype none

// One pipeline stage: peels the decimal digit at position POS off the
// remaining quotient and passes the rest on.
module dss_div_stage #(
  parameter int POS = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           feed_valid,
  output logic                feed_ready,
  input  wire dss_pkg::work_t feed,
  output logic                done_valid,
  input  wire logic           done_ready,
  output dss_pkg::work_t      done
);

  logic [dss_pkg::ProdW-1:0]  prod;
  logic [dss_pkg::ValueW-1:0] quot;
  logic [dss_pkg::ValueW-1:0] rem_full;
  dss_pkg::work_t             work_next;

  // Divide by ten through the reciprocal, remainder by shift-add
  always_comb begin
    prod      = dss_pkg::ProdW'(feed.rest) * dss_pkg::ProdW'(dss_pkg::Recip10);
    quot      = dss_pkg::ValueW'(prod >> dss_pkg::RecipShift);
    rem_full  = feed.rest - ((quot << 3) + (quot << 1));
    work_next = feed;
    work_next.rest = quot;
    work_next.digits[POS] = rem_full[dss_pkg::DigitW-1:0];
  end

  // Stage moves whenever it is empty or its contents leave
  assign feed_ready = !done_valid || done_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
    end else if (feed_ready) begin
      done_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_ready && feed_valid) begin
      done <= work_next;
    end
  end

endmodule

`default_nettype wire

[rtl/dss_scan.sv]
`default_nettype none

// Holds one value's digits and shows them one per cycle while the result side is ready, most significant first.
module dss_scan #(
  parameter int COUNT = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             feed_valid,
  output logic                  feed_ready,
  input  wire dss_pkg::digits_t feed,
  dss_digit_if.source           digit
);

  logic             busy;
  logic [1:0]       idx;
  logic [1:0]       sel;
  logic             at_last;
  dss_pkg::digits_t held;

  assign at_last    = (idx == 2'(COUNT - 1));
  assign feed_ready = !busy || (digit.ready && at_last);

  // Scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (feed_valid && feed_ready) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && digit.ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      held <= feed;
    end
  end

  // Result fields straight from the held digits and the scan counter
  always_comb begin
    sel                  = 2'(COUNT - 1) - idx;
    digit.valid          = busy;
    digit.segments       = dss_pkg::seg_of(held[sel]);
    digit.digit_enable_n = ~(dss_pkg::EnW'(1) << idx);
    digit.last           = at_last;
  end

endmodule

`default_nettype wire

[rtl/dss_check.sv]
`default_nettype none
`include "seven_segment_digit_scan_defines.svh"

// Port-level checks on the result side.
module dss_check #(
  parameter int DIGITS = 4
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    valid,
  input wire logic                    ready,
  input wire logic [dss_pkg::EnW-1:0] en_n,
  input wire logic                    last
);

  localparam int Scan = (DIGITS < 1) ? 1 :
                        (DIGITS > dss_pkg::MaxScan) ? dss_pkg::MaxScan : DIGITS;
  localparam logic [dss_pkg::EnW-1:0] LastEn = ~(dss_pkg::EnW'(1) << (Scan - 1));

  // A shown result stays until taken
  `DSS_ASSERT_NEXT(a_hold, valid && !ready, valid)
  // Exactly one digit driven
  `DSS_ASSERT_NOW(a_onehot, valid, $onehot(~en_n))
  // The final digit is the one flagged last
  `DSS_ASSERT_NOW(a_last, valid, last == (en_n == LastEn))
  // Digits of one value follow each other without a gap
  `DSS_ASSERT_NEXT(a_walk, valid && ready && !last,
                   valid && (~en_n == dss_pkg::EnW'(~$past(en_n) << 1)))

endmodule

bind seven_segment_digit_scan dss_check #(
  .DIGITS (DIGITS)
) u_dss_check (
  .clk   (clk),
  .rst   (rst),
  .valid (digit.valid),
  .ready (digit.ready),
  .en_n  (digit.digit_enable_n),
  .last  (digit.last)
);

`default_nettype wire
